// ----- rtl/core/plg_pkg.sv -----
package plg_pkg;

  // filter and arithmetic constants
  localparam logic [7:0]  UdpProtocol = 8'd17;
  localparam logic [31:0] RoundHalf   = 32'd512;
  localparam logic [29:0] MhzScale    = 30'd1000000;
  localparam int          BlockShift  = 10;

  // field and datapath widths
  localparam int TsW      = 32;
  localparam int SeqW     = 32;
  localparam int KW       = 30;
  localparam int BtW      = 53;
  localparam int GapW     = 32;
  localparam int SpbW     = 8;
  localparam int MulSteps = 32;
  localparam int DivSteps = 53;

  // register map, word index = paddr[3:2]
  localparam logic [1:0] RegListenPort = 2'd0;
  localparam logic [1:0] RegClockA     = 2'd1;
  localparam logic [1:0] RegClockB     = 2'd2;

  localparam logic [15:0] ListenPortRst = 16'd4346;
  localparam logic [9:0]  ClockARst     = 10'd200;
  localparam logic [9:0]  ClockBRst     = 10'd160;

  typedef struct packed {
    logic [7:0]  ip_protocol;
    logic [15:0] dest_port;
    logic [31:0] timestamp_sec;
    logic [31:0] block_seq;
    logic [7:0]  samples_per_block;
  } plg_in_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] gap_blocks;
    logic [31:0] loss_total;
    logic [31:0] packet_count;
  } plg_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StMulPrev,
    StMulCur,
    StSpan,
    StDiv,
    StNext,
    StDone
  } plg_state_e;

endpackage

// ----- rtl/core/packet_loss_gap_tracker_top.sv -----
// a filtered-out or first packet goes from the accepting edge to the done state, which loads the
//   output register; a tracked packet with a predecessor first runs both clock passes
// sequencing: one transaction at a time, next accepted the cycle after the result loads (which
//   can wait on the output stall); four block-time multiplies and up to two divides per packet
// reset: rst_ni clears the tracking state, both totals and the output valid, and loads the
//   register defaults (port 4346, clocks 200 and 160 MHz)
module packet_loss_gap_tracker_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  // header input
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  plg_pkg::plg_in_t in_data_i,
  // result output
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output plg_pkg::plg_out_t out_data_o,
  // register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] listen_port_q;
  logic [9:0]  clock_a_q, clock_b_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_port_q <= plg_pkg::ListenPortRst;
      clock_a_q     <= plg_pkg::ClockARst;
      clock_b_q     <= plg_pkg::ClockBRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        plg_pkg::RegListenPort: listen_port_q <= pwdata[15:0];
        plg_pkg::RegClockA:     clock_a_q     <= pwdata[9:0];
        plg_pkg::RegClockB:     clock_b_q     <= pwdata[9:0];
        default: ;  // unmapped word, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      plg_pkg::RegListenPort: prdata = {16'b0, listen_port_q};
      plg_pkg::RegClockA:     prdata = {22'b0, clock_a_q};
      plg_pkg::RegClockB:     prdata = {22'b0, clock_b_q};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  plg_pkg::plg_state_e state_q, state_d;
  logic sel_q, sel_d;          // 0: clock a pass, 1: clock b pass
  logic mul_start, mul_cur, div_start, out_load;

  // tracking state from the previous accepted packet
  logic                          have_prev_q;
  logic [plg_pkg::TsW-1:0]       prev_ts_q;
  logic [plg_pkg::SeqW-1:0]      prev_seq_q;
  logic [plg_pkg::SpbW-1:0]      prev_spb_q;
  logic [31:0]                   loss_q, count_q;

  // current packet
  logic                          ok_q;
  logic [plg_pkg::TsW-1:0]       cur_ts_q;
  logic [plg_pkg::SeqW-1:0]      cur_seq_q;
  logic [plg_pkg::SpbW-1:0]      cur_spb_q;
  logic [plg_pkg::BtW-1:0]       tp_q;
  logic [plg_pkg::GapW-1:0]      gap_a_q, gap_b_q;

  // output register
  logic                          out_valid_q;
  plg_pkg::plg_out_t             out_q;

  logic in_ok;
  assign in_ok = (in_data_i.ip_protocol == plg_pkg::UdpProtocol)
               && (in_data_i.dest_port == listen_port_q);

  // ---------------------------------------------------------------------------
  // shared block-time multiplier and divider
  // ---------------------------------------------------------------------------
  logic [plg_pkg::KW-1:0]   k_a, k_b, mul_k;
  logic [plg_pkg::TsW-1:0]  mul_ts;
  logic [plg_pkg::SeqW-1:0] mul_seq;
  logic                     mul_done, div_done;
  logic [plg_pkg::BtW-1:0]  mul_res;
  logic [plg_pkg::GapW-1:0] div_quo;

  // ticks per second of each candidate clock, registered inside the multiplier at start
  assign k_a     = {20'b0, clock_a_q} * plg_pkg::MhzScale;
  assign k_b     = {20'b0, clock_b_q} * plg_pkg::MhzScale;
  assign mul_k   = sel_d ? k_b : k_a;
  assign mul_ts  = mul_cur ? cur_ts_q : prev_ts_q;
  assign mul_seq = mul_cur ? cur_seq_q : prev_seq_q;

  plg_blk_time u_blk_time (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .ts_i    (mul_ts),
    .seq_i   (mul_seq),
    .k_i     (mul_k),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // span between the two packets; the multiplier result still holds the current block time
  logic                    same_sec, span_neg, span_zero;
  logic [plg_pkg::BtW-1:0] span;

  always_comb begin
    same_sec = (cur_ts_q == prev_ts_q);
    if (same_sec) begin
      span_neg = prev_seq_q > cur_seq_q;
      span     = {21'b0, cur_seq_q - prev_seq_q};
    end else begin
      span_neg = tp_q > mul_res;
      span     = mul_res - tp_q;
    end
    // out of order or no samples per block: candidate stays zero
    span_zero = span_neg || (prev_spb_q == '0);
  end

  plg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (span),
    .den_i   (prev_spb_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // ---------------------------------------------------------------------------
  // sequencer: per clock, block times (previous, current), divide unless span_zero
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plg_pkg::StIdle;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    mul_start = 1'b0;
    mul_cur   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      plg_pkg::StIdle: begin
        if (in_valid_i) begin
          sel_d = 1'b0;
          if (in_ok && have_prev_q) begin
            mul_start = 1'b1;
            state_d   = plg_pkg::StMulPrev;
          end else begin
            state_d = plg_pkg::StDone;
          end
        end
      end
      plg_pkg::StMulPrev: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_cur   = 1'b1;
          state_d   = plg_pkg::StMulCur;
        end
      end
      plg_pkg::StMulCur: begin
        if (mul_done) state_d = plg_pkg::StSpan;
      end
      plg_pkg::StSpan: begin
        if (span_zero) begin
          state_d = plg_pkg::StNext;
        end else begin
          div_start = 1'b1;
          state_d   = plg_pkg::StDiv;
        end
      end
      plg_pkg::StDiv: begin
        if (div_done) state_d = plg_pkg::StNext;
      end
      plg_pkg::StNext: begin
        if (!sel_q) begin
          sel_d     = 1'b1;
          mul_start = 1'b1;
          state_d   = plg_pkg::StMulPrev;
        end else begin
          state_d = plg_pkg::StDone;
        end
      end
      plg_pkg::StDone: begin
        // output register free or being emptied this cycle
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = plg_pkg::StIdle;
        end
      end
      default: state_d = plg_pkg::StIdle;
    endcase
  end

  assign in_stall_o = (state_q != plg_pkg::StIdle);

  // ---------------------------------------------------------------------------
  // merge, loss and count update
  // ---------------------------------------------------------------------------
  logic [plg_pkg::GapW-1:0] gap_m;
  logic [32:0]              loss_sum;
  logic [31:0]              loss_d, count_d;

  always_comb begin
    if ((gap_a_q != '0) && (gap_b_q != '0)) begin
      gap_m = (gap_a_q < gap_b_q) ? gap_a_q : gap_b_q;
    end else begin
      gap_m = (gap_a_q != '0) ? gap_a_q : gap_b_q;
    end
    loss_sum = {1'b0, loss_q} + {1'b0, gap_m - 32'd1};
    loss_d   = loss_q;
    if (ok_q && (gap_m > 32'd1)) begin
      loss_d = loss_sum[32] ? '1 : loss_sum[31:0];
    end
    count_d = count_q;
    if (ok_q && (count_q != '1)) begin
      count_d = count_q + 32'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if ((state_q == plg_pkg::StIdle) && in_valid_i) begin
      ok_q      <= in_ok;
      cur_ts_q  <= in_data_i.timestamp_sec;
      cur_seq_q <= in_data_i.block_seq;
      cur_spb_q <= in_data_i.samples_per_block;
      gap_a_q   <= '0;
      gap_b_q   <= '0;
    end
    if ((state_q == plg_pkg::StMulPrev) && mul_done) begin
      tp_q <= mul_res;
    end
    if ((state_q == plg_pkg::StDiv) && div_done) begin
      if (sel_q) begin
        gap_b_q <= div_quo;
      end else begin
        gap_a_q <= div_quo;
      end
    end
    if (out_load && ok_q) begin
      prev_ts_q  <= cur_ts_q;
      prev_seq_q <= cur_seq_q;
      prev_spb_q <= cur_spb_q;
    end
    if (out_load) begin
      out_q.accepted     <= ok_q;
      out_q.gap_blocks   <= gap_m;
      out_q.loss_total   <= loss_d;
      out_q.packet_count <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      loss_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        loss_q      <= loss_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
        if (ok_q) have_prev_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a filtered-out packet never reports a gap
  a_reject_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.accepted |-> out_data_o.gap_blocks == '0)
    else $error("rejected transaction carries a nonzero gap");

  // an accepted packet is always counted
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |-> out_data_o.packet_count != '0)
    else $error("accepted transaction with zero packet count");

  // the loss total never goes backward
  a_loss_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> loss_q >= $past(loss_q))
    else $error("loss total decreased");

  // a result is only loaded when the output register can take it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || !out_stall_i)
    else $error("output register overwritten while stalled");

endmodule

// ----- rtl/core/plg_blk_time.sv -----
module plg_blk_time (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [plg_pkg::TsW-1:0]     ts_i,
  input  logic [plg_pkg::SeqW-1:0]    seq_i,
  input  logic [plg_pkg::KW-1:0]      k_i,
  output logic                        done_o,
  output logic [plg_pkg::BtW-1:0]     res_o
);

  // right-shifting serial multiplier: one timestamp bit per cycle,
  // accumulator preloaded with the rounding half
  logic [31:0]                hi_q, lo_q;
  logic [plg_pkg::TsW-1:0]    ts_q;
  logic [plg_pkg::SeqW-1:0]   seq_q;
  logic [plg_pkg::KW-1:0]     k_q;
  logic [5:0]                 cnt_q;
  logic                       busy_q, done_q;
  logic [plg_pkg::BtW-1:0]    res_q;
  logic [32:0]                sum;
  logic [63:0]                wide;

  assign sum  = {1'b0, hi_q} + (ts_q[0] ? {3'b0, k_q} : 33'd0);
  assign wide = {hi_q, lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 6'(plg_pkg::MulSteps)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q  <= plg_pkg::RoundHalf;
      lo_q  <= '0;
      ts_q  <= ts_i;
      seq_q <= seq_i;
      k_q   <= k_i;
    end else if (busy_q) begin
      if (cnt_q == 6'(plg_pkg::MulSteps)) begin
        // drop the low block bits, then add the sequence number
        res_q <= wide[plg_pkg::BlockShift+plg_pkg::BtW-1:plg_pkg::BlockShift]
                 + {21'b0, seq_q};
      end else begin
        hi_q <= sum[32:1];
        lo_q <= {sum[0], lo_q[31:1]};
        ts_q <= {1'b0, ts_q[plg_pkg::TsW-1:1]};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- rtl/core/plg_div.sv -----
module plg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [plg_pkg::BtW-1:0]     num_i,
  input  logic [plg_pkg::SpbW-1:0]    den_i,
  output logic                        done_o,
  output logic [plg_pkg::GapW-1:0]    quo_o
);

  // restoring divider, one quotient bit per cycle; bits above the
  // result width only set a saturation flag
  logic [plg_pkg::BtW-1:0]    num_q;
  logic [plg_pkg::SpbW-1:0]   den_q, rem_q;
  logic [plg_pkg::GapW-1:0]   q_q;
  logic                       sat_q;
  logic [5:0]                 cnt_q;
  logic                       busy_q, done_q;
  logic [8:0]                 rem_sh, rem_sub;
  logic                       ge;

  assign rem_sh  = {rem_q, num_q[plg_pkg::BtW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(plg_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      q_q   <= '0;
      sat_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[plg_pkg::BtW-2:0], 1'b0};
      rem_q <= ge ? rem_sub[7:0] : rem_sh[7:0];
      q_q   <= {q_q[plg_pkg::GapW-2:0], ge};
      sat_q <= sat_q | q_q[plg_pkg::GapW-1];
    end
  end

  assign done_o = done_q;
  assign quo_o  = sat_q ? '1 : q_q;

endmodule

// ----- tb/gap_tracker_checker.sv -----
`timescale 1ns / 1ps

module gap_tracker_checker
  import plg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  plg_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  plg_out_t    out_data_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam logic [63:0] TicksPerMhz = 64'd1_000_000;
  localparam logic [63:0] HalfBlock   = 64'd512;
  localparam int          BlockBits   = 10;
  localparam logic [31:0] AllOnes     = 32'hFFFF_FFFF;

  // shadow registers and tracking state
  logic [15:0] listen_port;
  logic [9:0]  clock_a;
  logic [9:0]  clock_b;
  logic        seen_first;
  logic [31:0] last_ts;
  logic [31:0] last_seq;
  logic [7:0]  last_spb;
  logic [31:0] loss_sum;
  logic [31:0] packet_sum;

  plg_out_t    due_results[$];
  int unsigned mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
  endtask

  // block position on the sample clock, rounded to whole blocks
  function automatic logic [63:0] block_index(input logic [31:0] ts, input logic [31:0] seq,
                                              input logic [9:0] mhz);
    return ((64'(ts) * 64'(mhz) * TicksPerMhz + HalfBlock) >> BlockBits) + 64'(seq);
  endfunction

  function automatic logic [31:0] clock_gap(input plg_in_t hdr, input logic [9:0] mhz);
    logic [63:0] span;
    logic [63:0] from_blk;
    logic [63:0] to_blk;
    logic [63:0] quot;
    span = '0;
    if (last_spb == 8'd0) return '0;
    if (hdr.timestamp_sec == last_ts) begin
      if (last_seq > hdr.block_seq) return '0;
      span = 64'(hdr.block_seq - last_seq);
    end else begin
      from_blk = block_index(last_ts, last_seq, mhz);
      to_blk   = block_index(hdr.timestamp_sec, hdr.block_seq, mhz);
      if (from_blk > to_blk) return '0;
      span = to_blk - from_blk;
    end
    quot = span / 64'(last_spb);
    return (quot > 64'(AllOnes)) ? AllOnes : quot[31:0];
  endfunction

  function automatic plg_out_t track_header(input plg_in_t hdr);
    plg_out_t    res;
    logic [31:0] gap_a;
    logic [31:0] gap_b;
    logic [31:0] gap;
    gap = '0;
    res.accepted = (hdr.ip_protocol == UdpProtocol) && (hdr.dest_port == listen_port);
    if (res.accepted) begin
      if (seen_first) begin
        gap_a = clock_gap(hdr, clock_a);
        gap_b = clock_gap(hdr, clock_b);
        if (gap_a != 0 && gap_b != 0) begin
          gap = (gap_a < gap_b) ? gap_a : gap_b;
        end else begin
          gap = (gap_a != 0) ? gap_a : gap_b;
        end
        if (gap > 32'd1) begin
          loss_sum = (AllOnes - loss_sum < gap - 32'd1) ? AllOnes : loss_sum + gap - 32'd1;
        end
      end
      if (packet_sum != AllOnes) packet_sum++;
      seen_first = 1'b1;
      last_ts    = hdr.timestamp_sec;
      last_seq   = hdr.block_seq;
      last_spb   = hdr.samples_per_block;
    end
    res.gap_blocks   = gap;
    res.loss_total   = loss_sum;
    res.packet_count = packet_sum;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    plg_out_t want;
    if (!rst_ni) begin
      listen_port  = ListenPortRst;
      clock_a      = ClockARst;
      clock_b      = ClockBRst;
      seen_first   = 1'b0;
      last_ts      = '0;
      last_seq     = '0;
      last_spb     = '0;
      loss_sum     = '0;
      packet_sum   = '0;
      mismatches   = 0;
      due_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegListenPort: listen_port = pwdata[15:0];
          RegClockA:     clock_a = pwdata[9:0];
          RegClockB:     clock_b = pwdata[9:0];
          default:       ;
        endcase
      end
      // results first, so a new transaction never pairs with an older result
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due", out_data_i.gap_blocks, '0);
        end else begin
          want = due_results.pop_front();
          if (out_data_i.accepted !== want.accepted) begin
            report_mismatch("accepted", 32'(out_data_i.accepted), 32'(want.accepted));
          end
          if (out_data_i.gap_blocks !== want.gap_blocks) begin
            report_mismatch("gap_blocks", out_data_i.gap_blocks, want.gap_blocks);
          end
          if (out_data_i.loss_total !== want.loss_total) begin
            report_mismatch("loss_total", out_data_i.loss_total, want.loss_total);
          end
          if (out_data_i.packet_count !== want.packet_count) begin
            report_mismatch("packet_count", out_data_i.packet_count, want.packet_count);
          end
        end
      end
      if (in_valid_i && !in_stall_i) due_results.push_back(track_header(in_data_i));
      fail_count_o <= mismatches;
      pending_o    <= due_results.size();
    end
  end

endmodule

// ----- tb/packet_loss_gap_tracker_top_tb.sv -----
`timescale 1ns / 1ps

module packet_loss_gap_tracker_top_tb;
  import plg_pkg::*;

  // hang guard only, well beyond the length of the run
  localparam int unsigned RunLimit    = 5_000_000;
  // long receiver hold-off, well beyond one tracked packet
  localparam int unsigned SinkHold    = 600;
  localparam int unsigned PhaseSettle = 4;
  localparam int unsigned FinalSettle = 300;
  // word index past the register list, writes there must be dropped
  localparam logic [1:0]  RegSpare    = 2'd3;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  plg_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  plg_out_t    out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // knobs for the sender and the receiver
  bit          quiet         = 1'b0;
  bit          sink_hold_req = 1'b0;
  logic [15:0] port_now      = ListenPortRst;

  // header stream state: current second, block sequence and samples per block
  logic [31:0] s_ts;
  logic [31:0] s_seq;
  logic [7:0]  s_spb;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  packet_loss_gap_tracker_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // watches both channels and the register port, predicts and compares
  gap_tracker_checker gap_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RunLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall runs, mostly short, now and then long,
  // one long hold-off on request while the sender keeps offering
  initial begin : result_sink
    int unsigned pick;
    int unsigned run;
    logic        level;
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (SinkHold) @(posedge clk_i);
      end else if (quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          level = 1'b0;
          run   = $urandom_range(1, 20);
        end else if (pick < 85) begin
          level = 1'b1;
          run   = $urandom_range(1, 3);
        end else if (pick < 98) begin
          level = 1'b1;
          run   = $urandom_range(4, 15);
        end else begin
          level = 1'b1;
          run   = $urandom_range(30, 200);
        end
        out_stall_i <= level;
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // one register write: setup, then access, then the port returns to idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one header and hold it until the transaction completes,
  // then maybe leave the channel idle for a while
  task automatic offer(input logic [7:0] proto, input logic [15:0] port,
                       input logic [31:0] ts, input logic [31:0] seq,
                       input logic [7:0] spb);
    int unsigned pick;
    int unsigned idle;
    in_data_i  <= {proto, port, ts, seq, spb};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pick = $urandom_range(99);
    if (quiet || pick < 50) begin
      idle = 0;
    end else if (pick < 85) begin
      idle = $urandom_range(1, 3);
    end else if (pick < 97) begin
      idle = $urandom_range(4, 12);
    end else begin
      idle = $urandom_range(20, 300);
    end
    if (idle != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  // sender pauses until every result is back, then lets the block settle
  task automatic wait_drained(input int unsigned settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // mostly well-formed header streams with random content, plus filtered noise;
  // only packets that pass the filter count toward the goal
  task automatic run_traffic(input int unsigned tracked_goal, input bit wild);
    int unsigned tracked;
    int unsigned pick;
    tracked = 0;
    s_ts    = $urandom;
    s_seq   = $urandom;
    s_spb   = 8'd16;
    while (tracked < tracked_goal) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        // noise: anything, or one bit off the port or the protocol
        case ($urandom_range(2))
          0: offer(8'($urandom), 16'($urandom), $urandom, $urandom, 8'($urandom));
          1: offer(UdpProtocol, port_now ^ (16'd1 << $urandom_range(15)),
                   $urandom, $urandom, 8'($urandom));
          default: offer(UdpProtocol ^ (8'd1 << $urandom_range(7)), port_now,
                         $urandom, $urandom, 8'($urandom));
        endcase
      end else begin
        if (wild && pick >= 96) begin
          // arbitrary header, big jumps saturate the loss total
          s_ts  = $urandom;
          s_seq = $urandom;
          s_spb = 8'($urandom);
        end else if (pick < 65) begin
          // same second, usually the next block, sometimes a few lost
          s_seq += ((s_spb == 8'd0) ? 32'd1 : 32'(s_spb)) *
                   (($urandom_range(9) < 7) ? 32'd1 : 32'($urandom_range(8)));
        end else if (pick < 78) begin
          // next second or the one after restarts the block count
          s_ts  += 32'($urandom_range(1, 2));
          s_seq  = 32'($urandom_range(64));
        end else if (pick < 88) begin
          // late arrival: earlier block or earlier second
          if ($urandom_range(1) == 1) begin
            s_seq -= 32'($urandom_range(1, 300));
          end else begin
            s_ts -= 32'd1;
          end
        end else begin
          // arbitrary distance within the second
          s_seq += 32'($urandom_range(20000));
        end
        // samples per block changes now and then, zero included
        if ($urandom_range(9) == 0) begin
          s_spb = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        end
        offer(UdpProtocol, port_now, s_ts, s_seq, s_spb);
        tracked++;
      end
    end
  endtask

  initial begin : stimulus
    logic [31:0] value;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, register defaults: filter, first packet, loss, late arrivals,
    // zero samples, second change in both directions
    offer(8'd0, ListenPortRst, 32'd100, 32'd0, 8'd16);
    offer(UdpProtocol, ListenPortRst + 16'd1, 32'd100, 32'd0, 8'd16);
    offer(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    offer(UdpProtocol, ListenPortRst, 32'd100, 32'd0, 8'd16);
    offer(UdpProtocol, ListenPortRst, 32'd100, 32'd16, 8'd16);
    offer(UdpProtocol, ListenPortRst, 32'd100, 32'd96, 8'd16);
    offer(UdpProtocol, ListenPortRst ^ 16'd1, 32'd100, 32'd500, 8'd1);
    offer(UdpProtocol, ListenPortRst, 32'd100, 32'd50, 8'd16);
    offer(UdpProtocol, ListenPortRst, 32'd100, 32'd60, 8'd0);
    offer(UdpProtocol, ListenPortRst, 32'd100, 32'd1000, 8'd255);
    offer(UdpProtocol, ListenPortRst, 32'd101, 32'd0, 8'd255);
    offer(UdpProtocol, ListenPortRst, 32'd100, 32'd500, 8'd255);
    offer(UdpProtocol, ListenPortRst, 32'd100, 32'd500, 8'd1);
    offer(UdpProtocol, ListenPortRst, 32'd100, 32'd503, 8'd1);
    wait_drained(PhaseSettle);

    // slowest and fastest clocks, port zero; receiver holds off at the start
    port_now = 16'd0;
    write_reg(RegListenPort, 32'd0);
    write_reg(RegClockA, 32'd1);
    write_reg(RegClockB, 32'd1023);
    sink_hold_req = 1'b1;
    // next second but far back in blocks: only the fast clock sees a gap
    offer(UdpProtocol, port_now, 32'd10, 32'd500_000, 8'd1);
    offer(UdpProtocol, port_now, 32'd11, 32'd0, 8'd1);
    run_traffic(280, 1'b0);
    wait_drained(PhaseSettle);

    // clocks swapped, all-ones port, no idling on either side
    port_now = 16'hFFFF;
    write_reg(RegListenPort, 32'hFFFF_FFFF);
    write_reg(RegClockA, 32'd1023);
    write_reg(RegClockB, 32'd1);
    quiet = 1'b1;
    offer(UdpProtocol, port_now, 32'd10, 32'd500_000, 8'd1);
    offer(UdpProtocol, port_now, 32'd11, 32'd0, 8'd1);
    run_traffic(240, 1'b0);
    wait_drained(PhaseSettle);
    quiet = 1'b0;

    // first clock zero, so its block time is the sequence alone;
    // a write past the register list changes nothing
    value = $urandom;
    port_now = value[15:0];
    write_reg(RegListenPort, value);
    write_reg(RegClockA, 32'd0);
    write_reg(RegClockB, 32'($urandom_range(1, 1023)));
    write_reg(RegSpare, $urandom);
    run_traffic(280, 1'b0);
    wait_drained(PhaseSettle);

    // random settings with arbitrary headers mixed in
    value = $urandom;
    port_now = value[15:0];
    write_reg(RegListenPort, value);
    write_reg(RegClockA, 32'($urandom_range(1, 1023)));
    write_reg(RegClockB, 32'($urandom_range(1, 1023)));
    run_traffic(360, 1'b1);
    // widest gaps: full sequence range in one second, then a saturated
    // candidate across all seconds, which pins the loss total
    offer(UdpProtocol, port_now, 32'd5, 32'd0, 8'd1);
    offer(UdpProtocol, port_now, 32'd5, 32'hFFFF_FFFF, 8'd1);
    offer(UdpProtocol, port_now, 32'd0, 32'd0, 8'd1);
    offer(UdpProtocol, port_now, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1);
    offer(UdpProtocol, port_now, 32'hFFFF_FFFF, 32'd0, 8'hFF);
    offer(UdpProtocol, port_now, 32'hFFFF_FFFF, 32'd300, 8'd1);
    wait_drained(FinalSettle);

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
